@@ sv/poi_pkg.sv @@
`timescale 1ns / 1ps
package poi_pkg;

    typedef struct packed {
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [23:0] yaw_rate;
        logic        [15:0] elapsed;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] pos_x_out;
        logic signed [31:0] pos_y_out;
        logic        [31:0] heading_out;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } t_out_item;

    localparam int MAX_TABLE = 30;
    localparam logic signed [33:0] GAIN_START = 34'sd652032874;

    // arctangent of 2^-i in binary-angle units
    function automatic logic [31:0] atan_lut(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933406;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004756;
            5'd4:  r = 32'd42667331;
            5'd5:  r = 32'd21354465;
            5'd6:  r = 32'd10679838;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            5'd24: r = 32'd41;
            5'd25: r = 32'd20;
            5'd26: r = 32'd10;
            5'd27: r = 32'd5;
            5'd28: r = 32'd3;
            5'd29: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

@@ sv/poi_cordic.sv @@
`timescale 1ns / 1ps
module poi_cordic #(
    parameter int STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [31:0]        i_angle,
    output logic               o_done,
    output logic signed [33:0] o_cos,
    output logic signed [33:0] o_sin
);
    import poi_pkg::*;

    localparam int NSTEP = (STEPS < MAX_TABLE) ? STEPS : MAX_TABLE;

    logic               r_busy, n_busy;
    logic [4:0]         r_i, n_i;
    logic [1:0]         r_q, n_q;
    logic signed [33:0] r_x, n_x, r_y, n_y;
    logic signed [32:0] r_z, n_z;
    logic               r_done, n_done;

    logic [31:0]        w_qa;
    logic signed [33:0] w_dx, w_dy;

    // fold quadrant and run one rotation per cycle
    always_comb begin
        w_qa   = i_angle + 32'h2000_0000;
        w_dx   = r_y >>> r_i;
        w_dy   = r_x >>> r_i;
        n_busy = r_busy;
        n_i    = r_i;
        n_q    = r_q;
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
            n_i    = 5'd0;
            n_q    = w_qa[31:30];
            n_x    = GAIN_START;
            n_y    = '0;
            n_z    = 33'(signed'(i_angle - {w_qa[31:30], 30'd0}));
        end else if (r_busy) begin
            if (r_i == 5'(NSTEP)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                if (!r_z[32]) begin
                    n_x = r_x - w_dx;
                    n_y = r_y + w_dy;
                    n_z = r_z - 33'(atan_lut(r_i));
                end else begin
                    n_x = r_x + w_dx;
                    n_y = r_y - w_dy;
                    n_z = r_z + 33'(atan_lut(r_i));
                end
                n_i = r_i + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_i <= n_i;
        r_q <= n_q;
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    // unfold by quadrant
    always_comb begin
        case (r_q)
            2'd0:    begin o_cos = r_x;  o_sin = r_y;  end
            2'd1:    begin o_cos = -r_y; o_sin = r_x;  end
            2'd2:    begin o_cos = -r_x; o_sin = -r_y; end
            default: begin o_cos = r_y;  o_sin = -r_x; end
        endcase
    end
    assign o_done = r_done;

endmodule

@@ sv/planar_odometry_integrator_unit.sv @@
`timescale 1ns / 1ps
// Planar dead-reckoning odometry integrator.
// Input channel i_valid/o_ready carries one tick (velocities, yaw rate,
// elapsed time); output channel o_valid/i_ready carries the new pose.
// Each tick rotates the body velocity by the held heading, scales it by
// elapsed time, adds it to saturating Q16.16 x and y, advances the
// binary-angle heading, and gives sin/cos of half the new heading.
// Each tick is worked by two passes of one shared iterative CORDIC (one
// rotation per cycle), six shift-add products (one multiplier bit per
// cycle), a state that starts the second CORDIC pass and an output load.
// A new tick waits until the last one is loaded for output, as o_ready
// is high only while idle.
// Reset clears position and heading to zero and drops any transaction.
// When the receiver stalls the result holds in the output register; the
// next tick is still taken and worked, and waits at its end until the
// held result is delivered.
module planar_odometry_integrator_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  poi_pkg::t_in_item   i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output poi_pkg::t_out_item  o_data
);
    import poi_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_COR1  = 4'd1;
    localparam logic [3:0] S_M1    = 4'd2;
    localparam logic [3:0] S_M2    = 4'd3;
    localparam logic [3:0] S_M3    = 4'd4;
    localparam logic [3:0] S_M4    = 4'd5;
    localparam logic [3:0] S_PX    = 4'd6;
    localparam logic [3:0] S_PY    = 4'd7;
    localparam logic [3:0] S_HD    = 4'd8;
    localparam logic [3:0] S_COR2  = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0]         r_st, n_st;
    logic signed [31:0] r_px, r_py;
    logic [31:0]        r_hd;
    t_in_item           r_in;
    t_out_item          r_out;
    logic               r_oval;
    logic signed [33:0] r_c, r_s;
    logic               w_start;
    logic [31:0]        w_ang;
    logic               w_done;
    logic signed [33:0] w_cos, w_sin;
    logic               w_free;

    // serial multiplier: r_acc += r_mcand when multiplier bit set
    logic signed [65:0] r_acc, r_mcand;
    logic [15:0]        r_mplier;
    logic [4:0]         r_cnt;
    logic               r_msign;
    logic signed [65:0] r_sum1, r_sum2;

    poi_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_angle (w_ang),
        .o_done  (w_done),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    assign o_ready = (r_st == S_IDLE);
    assign o_valid = r_oval;
    assign o_data  = r_out;
    assign w_free  = !r_oval || i_ready;
    assign w_ang   = (r_st == S_HD) ? {1'b0, r_hd[31:1]} : r_hd;
    assign w_start = (r_st == S_IDLE && i_valid) || (r_st == S_HD);

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                    input logic signed [65:0] p);
        logic signed [66:0] t;
        logic signed [66:0] v;
        t = (67'(p) + 67'sd137438953472) >>> 38;
        v = 67'(a) + t;
        if (v > 67'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -67'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic signed [15:0] to_q15(input logic signed [33:0] v);
        logic signed [34:0] r;
        r = (35'(v) + 35'sd16384) >>> 15;
        if (r > 35'sd32767) return 16'sh7FFF;
        if (r < -35'sd32768) return 16'sh8000;
        return r[15:0];
    endfunction

    // load a product: 16-bit multiplier, signed when sg, against a wide multiplicand
    task automatic load_mul(input logic [15:0] m, input logic signed [65:0] d,
                            input logic sg);
        r_mplier <= m;
        r_mcand  <= d;
        r_msign  <= sg;
        r_acc    <= '0;
        r_cnt    <= 5'd0;
    endtask

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE: if (i_valid) n_st = S_COR1;
            S_COR1: if (w_done)  n_st = S_M1;
            S_M1:   if (r_cnt == 5'd16) n_st = S_M2;
            S_M2:   if (r_cnt == 5'd16) n_st = S_M3;
            S_M3:   if (r_cnt == 5'd16) n_st = S_M4;
            S_M4:   if (r_cnt == 5'd16) n_st = S_PX;
            S_PX:   if (r_cnt == 5'd16) n_st = S_PY;
            S_PY:   if (r_cnt == 5'd16) n_st = S_HD;
            S_HD:   n_st = S_COR2;
            S_COR2: if (w_done)  n_st = S_OUT;
            S_OUT:  if (w_free)  n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_px   <= '0;
            r_py   <= '0;
            r_hd   <= '0;
            r_oval <= 1'b0;
            r_cnt  <= 5'd16;
        end else begin
            r_st <= n_st;
            // hold the result until taken; load marks it valid
            if (r_st == S_OUT && w_free) r_oval <= 1'b1;
            else if (i_ready)            r_oval <= 1'b0;
            // advance one multiplier bit; top bit of signed multiplier subtracts
            if (r_cnt != 5'd16) begin
                if (r_mplier[0]) begin
                    if (r_cnt == 5'd15 && r_msign) r_acc <= r_acc - r_mcand;
                    else                           r_acc <= r_acc + r_mcand;
                end
                r_mplier <= {1'b0, r_mplier[15:1]};
                r_mcand  <= r_mcand <<< 1;
                r_cnt    <= r_cnt + 5'd1;
            end
            unique case (r_st)
                S_IDLE: if (i_valid) begin
                    r_in  <= i_data;
                end
                S_COR1: if (w_done) begin
                    r_c <= w_cos;
                    r_s <= w_sin;
                    load_mul(r_in.vel_x, 66'(w_cos), 1'b1);
                end
                S_M1: if (r_cnt == 5'd16) begin
                    r_sum1 <= r_acc;
                    load_mul(r_in.vel_y, 66'(r_s), 1'b1);
                end
                S_M2: if (r_cnt == 5'd16) begin
                    r_sum1 <= r_sum1 - r_acc;
                    load_mul(r_in.vel_x, 66'(r_s), 1'b1);
                end
                S_M3: if (r_cnt == 5'd16) begin
                    r_sum2 <= r_acc;
                    load_mul(r_in.vel_y, 66'(r_c), 1'b1);
                end
                S_M4: if (r_cnt == 5'd16) begin
                    r_sum2 <= r_sum2 + r_acc;
                    load_mul(r_in.elapsed, r_sum1, 1'b0);
                end
                S_PX: if (r_cnt == 5'd16) begin
                    r_px <= sat_add(r_px, r_acc);
                    load_mul(r_in.elapsed, r_sum2, 1'b0);
                end
                S_PY: if (r_cnt == 5'd16) begin
                    r_py <= sat_add(r_py, r_acc);
                    r_hd <= r_hd + 32'(40'(signed'(r_in.yaw_rate))
                                   * 40'(r_in.elapsed));
                end
                S_HD: ;
                S_COR2: if (w_done) begin
                    r_c <= w_cos;
                    r_s <= w_sin;
                end
                S_OUT: if (w_free) begin
                    r_out.pos_x_out   <= r_px;
                    r_out.pos_y_out   <= r_py;
                    r_out.heading_out <= r_hd;
                    r_out.quat_z      <= to_q15(r_s);
                    r_out.quat_w      <= to_q15(r_c);
                end
                default: ;
            endcase
        end
    end

endmodule
